### sv/qdsa_pkg.sv
package qdsa_pkg;

    localparam int ADC_BITS_DEF      = 12;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TAB_LEN           = 24;
    localparam int Q15_MAX           = 32767;
    localparam int NQ_W              = 17;   // signed q1.15
    localparam int M_W               = 16;   // magnitude q.15
    localparam int CW                = 48;   // cordic datapath
    localparam int ZW                = 26;   // angle, 1/65536 degree
    localparam logic [15:0] GEOM_RESET = 16'd18939;
    localparam int ADDR_GEOM         = 0;
    localparam int DEG_ONE           = 65536;

    typedef struct packed {
        logic vld;
        logic err;
        logic ctr;
    } t_ctl;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0: v = 26'sd2949120;
            1: v = 26'sd1740967;
            2: v = 26'sd919879;
            3: v = 26'sd466945;
            4: v = 26'sd234379;
            5: v = 26'sd117304;
            6: v = 26'sd58666;
            7: v = 26'sd29335;
            8: v = 26'sd14668;
            9: v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/quad_diode_sun_angle.sv
// throughput: one request per cycle; busy is always low, o_done pulses once per request
// depth: divider 18 (load plus 17 bit stages), square 1, root 17, ratio product 1,
// cordic one per stage, output conversion 2
// reset: synchronous active-low i_rst_n clears the valid pipeline and loads geometry_ratio 18939
// the receiver cannot stall: each result shows for exactly one cycle with o_done
module quad_diode_sun_angle #(
    parameter int ADC_BITS      = qdsa_pkg::ADC_BITS_DEF,
    parameter int CORDIC_STAGES = qdsa_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] i_diode_a,
    input  logic [11:0] i_diode_b,
    input  logic [11:0] i_diode_c,
    input  logic [11:0] i_diode_d,
    output logic        o_done,
    output logic [13:0] o_elevation_centideg,
    output logic [15:0] o_azimuth_centideg,
    output logic        o_zero_sum_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qdsa_pkg::*;

    localparam int DW  = ADC_BITS + 2;
    localparam int NSC = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
    localparam int DLY = 1 + 17 + 1;   // square, sqrt with rounding, product
    localparam int DLY_AZ = 1;         // prerotate

    // ---------------- configuration register ----------------
    logic [15:0] r_geom;
    logic        n_wr;
    assign n_wr   = psel && penable && pwrite && (paddr[1:0] == 2'(ADDR_GEOM * 4));
    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'(ADDR_GEOM * 4)) ? {16'd0, r_geom} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom <= GEOM_RESET;
        end else if (n_wr) begin
            r_geom <= pwdata[15:0];
        end
    end

    // every cycle is open for a new request
    assign busy = 1'b0;

    // ---------------- stage 0: sums and differences ----------------
    logic [ADC_BITS-1:0] n_a, n_b, n_c, n_d;
    assign n_a = ADC_BITS'(i_diode_a);
    assign n_b = ADC_BITS'(i_diode_b);
    assign n_c = ADC_BITS'(i_diode_c);
    assign n_d = ADC_BITS'(i_diode_d);

    logic [DW-1:0]        r_sum;
    logic signed [DW:0]   r_nxn, r_nyn;
    logic                 r_v0;
    always_ff @(posedge i_clk) begin
        r_sum <= DW'(n_a) + DW'(n_b) + DW'(n_c) + DW'(n_d);
        r_nxn <= $signed({1'b0, DW'(n_b) + DW'(n_c)}) - $signed({1'b0, DW'(n_a) + DW'(n_d)});
        r_nyn <= $signed({1'b0, DW'(n_a) + DW'(n_b)}) - $signed({1'b0, DW'(n_c) + DW'(n_d)});
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
    end

    logic          n_err0;
    logic [DW-1:0] n_den;
    assign n_err0 = (r_sum == '0);
    assign n_den  = n_err0 ? DW'(1) : r_sum;

    // ---------------- normalization dividers ----------------
    logic [DW-1:0] n_mx, n_my;
    assign n_mx = r_nxn[DW] ? DW'(-r_nxn) : DW'(r_nxn);
    assign n_my = r_nyn[DW] ? DW'(-r_nyn) : DW'(r_nyn);

    logic                     n_dvx, n_dvy;
    logic signed [NQ_W-1:0]   n_nx, n_ny;
    qdsa_div #(.ADC_BITS(ADC_BITS)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v0),
        .i_mag(n_mx), .i_neg(r_nxn[DW]), .i_den(n_den),
        .o_vld(n_dvx), .o_q(n_nx)
    );
    qdsa_div #(.ADC_BITS(ADC_BITS)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v0),
        .i_mag(n_my), .i_neg(r_nyn[DW]), .i_den(n_den),
        .o_vld(n_dvy), .o_q(n_ny)
    );

    // error flag travels alongside the divider
    logic r_err_d [18];
    always_ff @(posedge i_clk) begin
        r_err_d[0] <= n_err0;
        for (int k = 1; k < 18; k++) r_err_d[k] <= r_err_d[k-1];
    end

    // ---------------- magnitude: square, sqrt, times ratio ----------------
    // squares reach 2^30, so they are formed at full width
    logic signed [33:0] n_sqx, n_sqy;
    assign n_sqx = n_nx * n_nx;
    assign n_sqy = n_ny * n_ny;

    logic [31:0] r_sq;
    logic        r_vsq;
    always_ff @(posedge i_clk) begin
        r_sq <= n_sqx[31:0] + n_sqy[31:0];
        if (!i_rst_n) begin
            r_vsq <= 1'b0;
        end else begin
            r_vsq <= n_dvx;
        end
    end
    logic        n_vm;
    logic [16:0] n_m;
    qdsa_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_vsq), .i_val(r_sq),
        .o_vld(n_vm), .o_root(n_m)
    );
    logic [32:0] r_t;
    logic        r_vt;
    always_ff @(posedge i_clk) begin
        r_t <= 33'(r_geom) * 33'(n_m);
        if (!i_rst_n) begin
            r_vt <= 1'b0;
        end else begin
            r_vt <= n_vm;
        end
    end

    logic                  n_vphi;
    logic signed [ZW-1:0]  n_phi;
    qdsa_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_phi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_vt),
        .i_x(CW'(64'sd1 <<< 30)), .i_y($signed({15'd0, r_t})), .i_z('0),
        .o_vld(n_vphi), .o_z(n_phi)
    );

    // ---------------- azimuth: half-plane prerotation ----------------
    logic signed [CW-1:0] r_ax, r_ay;
    logic signed [ZW-1:0] r_az;
    logic                 r_va, r_ctr_a, r_err_a;
    always_ff @(posedge i_clk) begin
        if (n_nx < 0) begin
            r_ax <= -(CW'(n_nx) <<< 8);
            r_ay <= -(CW'(n_ny) <<< 8);
            r_az <= (n_ny >= 0) ? ZW'(180 * DEG_ONE) : -ZW'(180 * DEG_ONE);
        end else begin
            r_ax <= CW'(n_nx) <<< 8;
            r_ay <= CW'(n_ny) <<< 8;
            r_az <= '0;
        end
        r_ctr_a <= (n_nx == 0) && (n_ny == 0);
        r_err_a <= r_err_d[17];
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= n_dvy;
        end
    end
    logic                 n_vth;
    logic signed [ZW-1:0] n_ang;
    qdsa_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_az (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_va),
        .i_x(r_ax), .i_y(r_ay), .i_z(r_az),
        .o_vld(n_vth), .o_z(n_ang)
    );

    // side info delayed through the cordic depth
    t_ctl r_side [NSC+1];
    always_comb r_side[0] = '{vld: r_va, err: r_err_a, ctr: r_ctr_a};
    for (genvar s = 0; s < NSC; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s+1] <= '{vld: 1'b0, err: r_side[s].err, ctr: r_side[s].ctr};
            end else begin
                r_side[s+1] <= r_side[s];
            end
        end
    end

    // align azimuth branch to the longer elevation branch
    localparam int ALN = DLY - DLY_AZ;
    t_ctl                 r_actl [ALN+1];
    logic signed [ZW-1:0] r_aang [ALN+1];
    always_comb begin
        r_actl[0] = '{vld: n_vth, err: r_side[NSC].err, ctr: r_side[NSC].ctr};
        r_aang[0] = n_ang;
    end
    for (genvar s = 0; s < ALN; s++) begin : g_aln
        always_ff @(posedge i_clk) begin
            r_aang[s+1] <= r_aang[s];
            if (!i_rst_n) begin
                r_actl[s+1] <= '{vld: 1'b0, err: r_actl[s].err, ctr: r_actl[s].ctr};
            end else begin
                r_actl[s+1] <= r_actl[s];
            end
        end
    end

    // ---------------- output conversion, first stage: wrap and clamp ----------------
    localparam logic signed [ZW:0] FULL = (ZW+1)'(360 * DEG_ONE);
    localparam logic signed [ZW:0] QTR  = (ZW+1)'(90 * DEG_ONE);
    logic signed [ZW:0] n_th;
    logic        [ZW:0] n_ph;
    always_comb begin
        n_th = FULL - (ZW+1)'(r_aang[ALN]);
        if (n_th >= FULL) n_th = n_th - FULL;
        if (n_th < 0)     n_th = n_th + FULL;
        n_ph  = (n_phi < 0) ? '0 : ((ZW+1)'(n_phi) > QTR ? QTR : (ZW+1)'(n_phi));
    end

    logic [ZW:0] r_th, r_ph;
    logic        r_cv, r_cerr, r_cctr;
    always_ff @(posedge i_clk) begin
        r_th   <= n_th;
        r_ph   <= n_ph;
        r_cerr <= r_actl[ALN].err;
        r_cctr <= r_actl[ALN].ctr;
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= n_vphi;
        end
    end

    // ---------------- output conversion, second stage: scale to centidegrees ----------------
    logic [33:0] n_thc, n_phc;
    logic [15:0] n_tf;
    always_comb begin
        n_thc = (34'(r_th) * 34'd100 + 34'd32768) >> 16;
        n_tf  = (n_thc[15:0] >= 16'd36000) ? n_thc[15:0] - 16'd36000 : n_thc[15:0];
        n_phc = (34'(r_ph) * 34'd100 + 34'd32768) >> 16;
    end

    logic r_done, r_zerr;
    logic [13:0] r_el;
    logic [15:0] r_az_o;
    always_ff @(posedge i_clk) begin
        r_zerr <= r_cerr;
        r_el   <= r_cerr ? 14'd0 : n_phc[13:0];
        r_az_o <= (r_cerr || r_cctr) ? 16'd0 : n_tf;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_cv;
        end
    end
    assign o_done               = r_done;
    assign o_elevation_centideg = r_el;
    assign o_azimuth_centideg   = r_az_o;
    assign o_zero_sum_error     = r_zerr;

`ifndef SYNTHESIS
    // both branches must deliver the same request together
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_vphi == r_actl[ALN].vld) else $error("branch misalignment");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_zero_sum_error |-> o_elevation_centideg == 14'd0 &&
        o_azimuth_centideg == 16'd0) else $error("error result not zero");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_elevation_centideg <= 14'd9000 && o_azimuth_centideg < 16'd36000)
        else $error("angle out of range");
`endif
endmodule

### sv/qdsa_div.sv
// pipelined restoring divider: q = (num*32768 + den/2) / den, one bit per stage,
// then saturate to q1.15 and apply the sign
module qdsa_div #(
    parameter int ADC_BITS = qdsa_pkg::ADC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [ADC_BITS+1:0]          i_mag,
    input  logic                         i_neg,
    input  logic [ADC_BITS+1:0]          i_den,
    output logic                         o_vld,
    output logic signed [qdsa_pkg::NQ_W-1:0] o_q
);
    import qdsa_pkg::*;

    localparam int DW = ADC_BITS + 2;
    localparam int NW = DW + 16;     // dividend width
    localparam int QB = 17;          // quotient bits (quotient <= 32768)
    localparam int RW = DW + 1;

    logic [NW-1:0] r_num [QB+1];
    logic [RW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [DW-1:0] r_den [QB+1];
    logic          r_neg [QB+1];
    logic          r_v   [QB+1];

    logic [NW-1:0] n_dvd;
    assign n_dvd = NW'({i_mag, 15'd0}) + NW'(i_den >> 1);

    // num < den*2^QB, so the bits above the quotient range seed the remainder
    always_ff @(posedge i_clk) begin
        r_num[0] <= n_dvd;
        r_rem[0] <= RW'(n_dvd[NW-1:QB]);
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_neg[0] <= i_neg;
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_vld;
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_st
        logic [RW:0]   n_tr;
        logic [RW-1:0] n_rm;
        logic          n_ge;
        always_comb begin
            n_tr = {r_rem[s], r_num[s][QB-1-s]};
            n_ge = n_tr >= {2'b0, r_den[s]};
            n_rm = n_ge ? RW'(n_tr - {2'b0, r_den[s]}) : RW'(n_tr);
        end
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= n_rm;
            r_q[s+1]   <= {r_q[s][QB-2:0], n_ge};
            r_num[s+1] <= r_num[s];
            r_den[s+1] <= r_den[s];
            r_neg[s+1] <= r_neg[s];
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    logic [QB-1:0] n_qs;
    always_comb begin
        n_qs = (r_q[QB] > QB'(Q15_MAX)) ? QB'(Q15_MAX) : r_q[QB];
    end

    assign o_vld = r_v[QB];
    assign o_q   = r_neg[QB] ? -$signed({1'b0, n_qs[15:0]}) : $signed({1'b0, n_qs[15:0]});
endmodule

### sv/qdsa_sqrt.sv
// pipelined integer square root of a 31-bit value, rounded to nearest
module qdsa_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [31:0] i_val,
    output logic        o_vld,
    output logic [16:0] o_root
);
    import qdsa_pkg::*;

    localparam int NS = 16;

    logic [31:0] r_v  [NS+1];
    logic [33:0] r_rm [NS+1];
    logic [16:0] r_rt [NS+1];
    logic        r_ok [NS+1];

    always_comb begin
        r_v[0]  = i_val;
        r_rm[0] = '0;
        r_rt[0] = '0;
        r_ok[0] = i_vld;
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [33:0] n_tr;
        logic [33:0] n_tst;
        logic        n_ge;
        always_comb begin
            n_tr  = {r_rm[s][31:0], r_v[s][31-2*s -: 2]};
            n_tst = {15'd0, r_rt[s], 2'b01};
            n_ge  = n_tr >= n_tst;
        end
        always_ff @(posedge i_clk) begin
            r_rm[s+1] <= n_ge ? n_tr - n_tst : n_tr;
            r_rt[s+1] <= {r_rt[s][15:0], n_ge};
            r_v[s+1]  <= r_v[s];
            if (!i_rst_n) begin
                r_ok[s+1] <= 1'b0;
            end else begin
                r_ok[s+1] <= r_ok[s];
            end
        end
    end

    // remainder v - r^2 greater than r: round up
    logic [16:0] r_out;
    logic        r_ov;
    always_ff @(posedge i_clk) begin
        r_out <= (r_rm[NS] > {17'd0, r_rt[NS]}) ? r_rt[NS] + 17'd1 : r_rt[NS];
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_ok[NS];
        end
    end
    assign o_vld  = r_ov;
    assign o_root = r_out;
endmodule

### sv/qdsa_cordic.sv
// pipelined cordic vectoring, one rotation per stage
module qdsa_cordic #(
    parameter int CORDIC_STAGES = qdsa_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic signed [qdsa_pkg::CW-1:0]  i_x,
    input  logic signed [qdsa_pkg::CW-1:0]  i_y,
    input  logic signed [qdsa_pkg::ZW-1:0]  i_z,
    output logic                            o_vld,
    output logic signed [qdsa_pkg::ZW-1:0]  o_z
);
    import qdsa_pkg::*;

    localparam int NS = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;

    logic signed [CW-1:0] r_x [NS+1];
    logic signed [CW-1:0] r_y [NS+1];
    logic signed [ZW-1:0] r_z [NS+1];
    logic                 r_v [NS+1];

    always_comb begin
        r_x[0] = i_x;
        r_y[0] = i_y;
        r_z[0] = i_z;
        r_v[0] = i_vld;
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (!r_y[s][CW-1]) begin
                r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                r_z[s+1] <= r_z[s] + atan_tab(s);
            end else begin
                r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                r_z[s+1] <= r_z[s] - atan_tab(s);
            end
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    assign o_vld = r_v[NS];
    assign o_z   = r_z[NS];
endmodule

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qdsa_pkg::*;

    // stimulus and block ports
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [11:0] i_diode_a, i_diode_b, i_diode_c, i_diode_d;
    logic        o_done;
    logic [13:0] o_elevation_centideg;
    logic [15:0] o_azimuth_centideg;
    logic        o_zero_sum_error;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    quad_diode_sun_angle DUT (.*);

    // one predicted sun angle result
    typedef struct {
        logic [13:0] elev;
        logic [15:0] azim;
        logic        err;
    } t_angle;

    t_angle      angle_q[$];
    logic [15:0] ratio_shadow;
    int          mismatch_cnt;
    int          idle_pct;

    // deg 360 and 180 in 1/65536 degree
    localparam longint FULL_TURN = 64'sd360 * DEG_ONE;
    localparam longint HALF_TURN = 64'sd180 * DEG_ONE;
    localparam longint QTR_TURN  = 64'sd90 * DEG_ONE;
    localparam int     N_STAGES  = (CORDIC_STAGES_DEF > TAB_LEN) ? TAB_LEN
                                                                 : CORDIC_STAGES_DEF;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor shift of a signed value
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z;
        longint dx, dy;
        longint arc;
        z = 0;
        for (int i = 0; i < N_STAGES; i++) begin
            dx  = floor_shr(y, i);
            dy  = floor_shr(x, i);
            arc = longint'(atan_arc(i));
            if (y >= 0) begin
                x += dx; y -= dy; z += arc;
            end else begin
                x -= dx; y += dy; z -= arc;
            end
        end
        return z;
    endfunction

    // atan(2^-i) in 1/65536 degree, held locally
    function automatic longint atan_arc(int i);
        longint arcs[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return arcs[i];
    endfunction

    function automatic longint q15_of(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q   = (mag * 32768 + den / 2) / den;
        if (q > Q15_MAX) q = Q15_MAX;
        return (num < 0) ? -q : q;
    endfunction

    // operand stays below 2^31, so the root fits 16 bits
    function automatic longint root_nearest(longint v);
        longint r;
        r = 0;
        for (longint b = 64'd1 << 16; b != 0; b >>= 1)
            if ((r + b) * (r + b) <= v) r += b;
        if (v - r * r > r) r++;
        return r;
    endfunction

    function automatic t_angle predict_angles(logic [11:0] a, logic [11:0] b,
                                              logic [11:0] c, logic [11:0] d);
        t_angle res;
        longint la, lb, lc, ld, tot, nx, ny, mag, tilt, phi, th, base, vx, vy;
        longint phi_c, th_c;
        la = a; lb = b; lc = c; ld = d;
        tot = la + lb + lc + ld;
        res.err = 1'b0;
        if (tot == 0) begin
            res.elev = '0; res.azim = '0; res.err = 1'b1;
            return res;
        end
        nx   = q15_of(lb + lc - la - ld, tot);
        ny   = q15_of(la + lb - lc - ld, tot);
        mag  = root_nearest(nx * nx + ny * ny);
        tilt = longint'(ratio_shadow) * mag;
        phi  = vector_angle(64'sd1 << 30, tilt);
        if (phi < 0) phi = 0;
        if (phi > QTR_TURN) phi = QTR_TURN;
        phi_c = (phi * 100 + 32768) >>> 16;
        if (nx == 0 && ny == 0) begin
            th_c = 0;
        end else begin
            vx = nx * 256; vy = ny * 256; base = 0;
            // left half plane: turn the vector half a circle first
            if (vx < 0) begin
                base = (vy >= 0) ? HALF_TURN : -HALF_TURN;
                vx = -vx; vy = -vy;
            end
            th = FULL_TURN - (base + vector_angle(vx, vy));
            if (th >= FULL_TURN) th -= FULL_TURN;
            if (th < 0) th += FULL_TURN;
            th_c = (th * 100 + 32768) >>> 16;
            if (th_c >= 36000) th_c -= 36000;
        end
        res.elev = phi_c[13:0];
        res.azim = th_c[15:0];
        return res;
    endfunction

    // checker: every o_done pulse is one result
    always @(posedge i_clk) begin
        t_angle want;
        if (i_rst_n && o_done) begin
            if (angle_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result elev=%0d azim=%0d err=%0b",
                             o_elevation_centideg, o_azimuth_centideg, o_zero_sum_error);
            end else begin
                want = angle_q.pop_front();
                if (want.elev !== o_elevation_centideg || want.azim !== o_azimuth_centideg
                        || want.err !== o_zero_sum_error) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp elev=%0d azim=%0d err=%0b got %0d %0d %0b",
                                 want.elev, want.azim, want.err, o_elevation_centideg,
                                 o_azimuth_centideg, o_zero_sum_error);
                end
            end
        end
    end

    // one request; random sender gaps per idle_pct
    task automatic send_request(logic [11:0] a, logic [11:0] b, logic [11:0] c,
                                logic [11:0] d);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_diode_a <= a; i_diode_b <= b; i_diode_c <= c; i_diode_d <= d;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        angle_q.push_back(predict_angles(a, b, c, d));
    endtask

    task automatic go_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (angle_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_ratio(logic [15:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 2'(ADDR_GEOM * 4); pwdata <= {16'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        ratio_shadow = v;
        @(posedge i_clk);
    endtask

    // extremes, zero sum, centred spot, full offsets, each axis direction
    task automatic test_directed();
        send_request(0, 0, 0, 0);
        send_request(4095, 4095, 4095, 4095);
        send_request(1, 1, 1, 1);
        send_request(4095, 0, 0, 0);
        send_request(0, 4095, 0, 0);
        send_request(0, 0, 4095, 0);
        send_request(0, 0, 0, 4095);
        send_request(1, 0, 0, 0);
        send_request(0, 0, 0, 1);
        send_request(4095, 4095, 0, 0);
        send_request(0, 4095, 4095, 0);
        send_request(0, 0, 4095, 4095);
        send_request(4095, 0, 0, 4095);
        send_request(2048, 2047, 2048, 2047);
        send_request(100, 101, 100, 100);
        send_request(101, 100, 100, 100);
        send_request(12'hAAA, 12'h555, 12'hAAA, 12'h555);
        send_request(12'h555, 12'hAAA, 12'h555, 12'hAAA);
        send_request(1000, 1001, 1000, 999);
    endtask

    // mostly near-balanced spots, some wide random and some tiny sums that can be zero
    task automatic test_random(int count);
        logic [11:0] a, b, c, d;
        int base, spread;
        repeat (count) begin
            case ($urandom_range(9))
                0: begin
                    a = 12'($urandom); b = 12'($urandom);
                    c = 12'($urandom); d = 12'($urandom);
                end
                1: begin
                    a = 12'($urandom_range(3)); b = 12'($urandom_range(3));
                    c = 12'($urandom_range(3)); d = 12'($urandom_range(3));
                end
                default: begin
                    base   = $urandom_range(4095);
                    spread = $urandom_range(1, 400);
                    a = 12'(base + $urandom_range(spread)); b = 12'(base + $urandom_range(spread));
                    c = 12'(base + $urandom_range(spread)); d = 12'(base + $urandom_range(spread));
                end
            endcase
            send_request(a, b, c, d);
        end
    endtask

    initial begin
        timeout_run();
    end

    task automatic timeout_run();
        #20ms;
        $display("tb: failure");
        $finish;
    endtask

    initial begin
        logic [15:0] ratios[5] = '{16'd0, 16'd65535, 16'd18939, 16'd32768, 16'd1};
        int phases[4] = '{0, 60, 0, 11};
        mismatch_cnt = 0; idle_pct = 0;
        ratio_shadow = GEOM_RESET;
        start <= 1'b0;
        i_diode_a <= '0; i_diode_b <= '0; i_diode_c <= '0; i_diode_d <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        go_quiet();   // sender waits out every outstanding result
        for (int p = 0; p < 5; p++) begin
            write_ratio(ratios[p]);
            idle_pct = phases[p % 4];
            test_random(180);
            go_quiet();
        end

        if (mismatch_cnt == 0 && angle_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
